FILE: rtl/sqlts_pkg.sv
// Shared types and sizes for the SQL token splitter.
package sqlts_pkg;

	// Most results one input byte can cause
	localparam int MAX_RES = 4;
	localparam int RES_IDX_W = $clog2(MAX_RES);
	localparam int CNT_W = $clog2(MAX_RES + 1);

	// Queue between classifier and serializer
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// One result beat
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
	} res_t;

	// All results caused by one input byte
	typedef struct packed {
		logic [CNT_W-1:0]           cnt;
		res_t [MAX_RES-1:0]         res;
	} entry_t;

endpackage

FILE: rtl/sql_token_splitter_core.sv
// SQL token splitter: one query byte in, zero to four result beats out.
// The first beat of a byte passes the queue slot, the working entry and the output register.
// Throughput: one byte per cycle in unless the queue is full; one beat per cycle out unless
// out_stall holds it; a four-entry queue absorbs bytes whose k beats hold the serializer.
// Reset (arst_n low): lexer back to normal mode with no open token, queue and output empty.
module sql_token_splitter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        end_of_statement,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  char_out,
	output logic        last_of_run
);

	logic              push;
	logic              q_full;
	logic              q_empty;
	logic              pop;
	sqlts_pkg::entry_t push_entry;
	sqlts_pkg::entry_t head;

	sqlts_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.char_in          (char_in),
		.end_of_statement (end_of_statement),
		.q_full           (q_full),
		.push             (push),
		.push_entry       (push_entry)
	);

	sqlts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.empty      (q_empty),
		.head       (head)
	);

	sqlts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.char_out    (char_out),
		.last_of_run (last_of_run)
	);

endmodule

FILE: rtl/sqlts_front.sv
// Front end: accepts query bytes, runs the lexer state and builds result entries.
module sqlts_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           char_in,
	input  logic                 end_of_statement,
	input  logic                 q_full,
	output logic                 push,
	output sqlts_pkg::entry_t    push_entry
);

	localparam logic [1:0] KIND_BYTE      = 2'd0;
	localparam logic [1:0] KIND_END_TOKEN = 2'd1;
	localparam logic [1:0] KIND_END_STMT  = 2'd2;

	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [1:0] {
		MODE_NORMAL     = 2'd0,
		MODE_STRING     = 2'd1,
		MODE_QUOTE_PEND = 2'd2,
		MODE_OP_PEND    = 2'd3
	} mode_t;

	mode_t mode_q, mode_d;
	logic  qkind_q, qkind_d;
	logic  open_q, open_d;

	sqlts_pkg::entry_t ent;
	logic              accept;
	logic              do_normal;
	logic [7:0]        qbyte;

	// Append one result to an entry, capped at the entry size
	function automatic sqlts_pkg::entry_t add_res(sqlts_pkg::entry_t e, logic [1:0] k,
			logic [7:0] ch);
		sqlts_pkg::entry_t r;
		r = e;
		if (r.cnt < sqlts_pkg::CNT_W'(sqlts_pkg::MAX_RES)) begin
			r.res[r.cnt[sqlts_pkg::RES_IDX_W-1:0]].kind = k;
			r.res[r.cnt[sqlts_pkg::RES_IDX_W-1:0]].ch = (k == KIND_BYTE) ? ch : 8'd0;
			r.cnt = r.cnt + sqlts_pkg::CNT_W'(1);
		end
		return r;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_delim(logic [7:0] c);
		return (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_LPAREN) ||
			(c == CH_RPAREN) || (c == CH_EQ) || (c == CH_LT) ||
			(c == CH_GT) || (c == CH_BANG);
	endfunction

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign qbyte    = qkind_q ? CH_DQUOTE : CH_SQUOTE;

	// Classify the byte and build its result list
	always_comb begin
		mode_d    = mode_q;
		qkind_d   = qkind_q;
		open_d    = open_q;
		ent       = '0;
		do_normal = 1'b0;

		case (mode_q)
			MODE_STRING: begin
				ent = add_res(ent, KIND_BYTE, char_in);
				if (char_in == qbyte)
					mode_d = MODE_QUOTE_PEND;
			end
			MODE_QUOTE_PEND: begin
				if (char_in == qbyte) begin
					// doubled quote stays inside the string
					ent = add_res(ent, KIND_BYTE, char_in);
					mode_d = MODE_STRING;
				end else begin
					mode_d = MODE_NORMAL;
					if (open_d)
						ent = add_res(ent, KIND_END_TOKEN, 8'd0);
					open_d = 1'b0;
					do_normal = 1'b1;
				end
			end
			MODE_OP_PEND: begin
				mode_d = MODE_NORMAL;
				if (char_in == CH_EQ) begin
					// joined operator: <= >= !=
					ent = add_res(ent, KIND_BYTE, char_in);
					if (open_d)
						ent = add_res(ent, KIND_END_TOKEN, 8'd0);
					open_d = 1'b0;
				end else begin
					if (open_d)
						ent = add_res(ent, KIND_END_TOKEN, 8'd0);
					open_d = 1'b0;
					do_normal = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
				do_normal = 1'b1;
			end
		endcase

		// Normal lexing of the byte
		if (do_normal) begin
			if (char_in == CH_SQUOTE || char_in == CH_DQUOTE) begin
				if (open_d)
					ent = add_res(ent, KIND_END_TOKEN, 8'd0);
				ent = add_res(ent, KIND_BYTE, char_in);
				mode_d = MODE_STRING;
				qkind_d = (char_in == CH_DQUOTE);
				open_d = 1'b1;
			end else if (is_space(char_in)) begin
				if (open_d)
					ent = add_res(ent, KIND_END_TOKEN, 8'd0);
				open_d = 1'b0;
			end else if (is_delim(char_in)) begin
				if (open_d)
					ent = add_res(ent, KIND_END_TOKEN, 8'd0);
				ent = add_res(ent, KIND_BYTE, char_in);
				if (char_in == CH_LT || char_in == CH_GT || char_in == CH_BANG) begin
					mode_d = MODE_OP_PEND;
					open_d = 1'b1;
				end else begin
					ent = add_res(ent, KIND_END_TOKEN, 8'd0);
					open_d = 1'b0;
				end
			end else begin
				ent = add_res(ent, KIND_BYTE, char_in);
				open_d = 1'b1;
			end
		end

		// Final byte closes everything and returns to reset state
		if (end_of_statement) begin
			if (open_d)
				ent = add_res(ent, KIND_END_TOKEN, 8'd0);
			ent = add_res(ent, KIND_END_STMT, 8'd0);
			mode_d = MODE_NORMAL;
			qkind_d = 1'b0;
			open_d = 1'b0;
		end
	end

	assign push       = accept && (ent.cnt != '0);
	assign push_entry = ent;

	// Lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			qkind_q <= 1'b0;
			open_q  <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			qkind_q <= qkind_d;
			open_q  <= open_d;
		end
	end

endmodule

FILE: rtl/sqlts_queue.sv
// Short entry queue between the front end and the result serializer.
module sqlts_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sqlts_pkg::entry_t    push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output sqlts_pkg::entry_t    head
);

	sqlts_pkg::entry_t                  slot_q [sqlts_pkg::QUEUE_DEPTH];
	logic [sqlts_pkg::Q_PTR_W-1:0]      wr_ptr_q;
	logic [sqlts_pkg::Q_PTR_W-1:0]      rd_ptr_q;
	logic [sqlts_pkg::Q_CNT_W-1:0]      count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full    = (count_q == sqlts_pkg::Q_CNT_W'(sqlts_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + sqlts_pkg::Q_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + sqlts_pkg::Q_PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + sqlts_pkg::Q_CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - sqlts_pkg::Q_CNT_W'(1);
		end
	end

endmodule

FILE: rtl/sqlts_back.sv
// Back end: drains queued entries one result beat per cycle, unless out_stall holds it, into the output register.
module sqlts_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  sqlts_pkg::entry_t    head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic [7:0]           char_out,
	output logic                 last_of_run
);

	sqlts_pkg::entry_t                  cur_q;
	logic                               cur_valid_q;
	logic [sqlts_pkg::RES_IDX_W-1:0]    idx_q;
	logic                               out_valid_q;
	logic [1:0]                         kind_q;
	logic [7:0]                         char_q;
	logic                               last_q;
	logic                               advance;
	logic                               cur_last;

	assign advance  = cur_valid_q && (!out_valid_q || !out_stall);
	assign cur_last = ((sqlts_pkg::CNT_W'(idx_q) + sqlts_pkg::CNT_W'(1)) == cur_q.cnt);
	assign pop      = !q_empty && (!cur_valid_q || (advance && cur_last));

	// Working entry and beat index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (advance) begin
			if (cur_last)
				cur_valid_q <= 1'b0;
			else
				idx_q <= idx_q + sqlts_pkg::RES_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= cur_q.res[idx_q].kind;
			char_q <= cur_q.res[idx_q].ch;
			last_q <= cur_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign char_out    = char_q;
	assign last_of_run = last_q;

endmodule
